>>> hdl/pjt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pjt_pkg
// Shared types and constants of the periodic job timer table.
// ----------------------------------------------------------------------------
package pjt_pkg;

    localparam int MAX_JOBS_DEF = 16;
    localparam int TIME_W       = 64;
    localparam int TAG_W        = 16;
    localparam int QUEUE_DEPTH  = 2;

    typedef enum logic {
        OP_ADD  = 1'b0,
        OP_TICK = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        KIND_ADD_OK    = 2'd0,
        KIND_FULL      = 2'd1,
        KIND_FIRED     = 2'd2,
        KIND_IDLE_TICK = 2'd3
    } t_kind;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_SCAN = 1'b1
    } t_state;

    // Classified command: value is the interval for an add, the time for a tick.
    typedef struct packed {
        t_op               op;
        logic [TIME_W-1:0] value;
        logic [TAG_W-1:0]  tag;
    } t_cmd;

    typedef struct packed {
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] last_run;
        logic [TAG_W-1:0]  tag;
    } t_entry;

endpackage
`default_nettype wire

>>> hdl/pjt_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pjt_front
// Accepts input items, classifies them into commands and queues them for the
// job sequencer.
// ----------------------------------------------------------------------------
module pjt_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    // op
    input  wire logic [0:0]    i_s_tuser,
    // period_ms [63:0], job_tag [79:64], now_ms [143:80]
    input  wire logic [143:0]  i_s_tdata,
    output logic               o_cmd_valid,
    output pjt_pkg::t_cmd      o_cmd,
    input  wire logic          i_cmd_pop
);

    localparam int QD  = pjt_pkg::QUEUE_DEPTH;
    localparam int QAW = (QD > 1) ? $clog2(QD) : 1;
    localparam int QCW = $clog2(QD + 1);

    pjt_pkg::t_cmd  r_queue [QD];
    logic [QAW-1:0] r_head;
    logic [QAW-1:0] r_tail;
    logic [QCW-1:0] r_fill;

    pjt_pkg::t_cmd  w_cmd;
    logic           w_push;
    logic           w_pop;

    always_comb begin
        w_cmd.op  = pjt_pkg::t_op'(i_s_tuser[0]);
        w_cmd.tag = i_s_tdata[79:64];
        if (w_cmd.op == pjt_pkg::OP_TICK) begin
            w_cmd.value = i_s_tdata[143:80];
        end else begin
            w_cmd.value = i_s_tdata[63:0];
        end
    end

    assign o_s_tready  = (r_fill != QCW'(QD));
    assign w_push      = i_s_tvalid && o_s_tready;
    assign o_cmd_valid = (r_fill != '0);
    assign w_pop       = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_queue[r_head];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_queue[r_tail] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_fill <= '0;
        end else begin
            if (w_push) begin
                r_tail <= (r_tail == QAW'(QD - 1)) ? '0 : r_tail + QAW'(1);
            end
            if (w_pop) begin
                r_head <= (r_head == QAW'(QD - 1)) ? '0 : r_head + QAW'(1);
            end
            if (w_push && !w_pop) begin
                r_fill <= r_fill + QCW'(1);
            end else if (w_pop && !w_push) begin
                r_fill <= r_fill - QCW'(1);
            end
        end
    end

endmodule
`default_nettype wire

>>> hdl/pjt_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pjt_back
// Job sequencer: holds the job table, appends jobs, walks the table on a tick
// while compacting it, and drives the result register.
// ----------------------------------------------------------------------------
module pjt_back #(
    parameter int MAX_JOBS = pjt_pkg::MAX_JOBS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cmd_valid,
    input  wire pjt_pkg::t_cmd             i_cmd,
    output logic                           o_cmd_pop,
    output logic                           o_m_tvalid,
    input  wire logic                      i_m_tready,
    // fired_tag
    output logic [pjt_pkg::TAG_W-1:0]      o_m_tdata,
    // kind
    output logic [1:0]                     o_m_tuser,
    output logic                           o_m_tlast
);

    localparam int IW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CW = $clog2(MAX_JOBS + 1);

    pjt_pkg::t_entry             r_table [MAX_JOBS];
    pjt_pkg::t_entry             r_rd_data;

    pjt_pkg::t_state             r_state;
    pjt_pkg::t_state             n_state;
    logic [CW-1:0]               r_count,    n_count;
    logic [CW-1:0]               r_rd,       n_rd;
    logic [CW-1:0]               r_wr,       n_wr;
    logic [pjt_pkg::TIME_W-1:0]  r_now,      n_now;
    logic                        r_pend,     n_pend;
    logic [pjt_pkg::TAG_W-1:0]   r_pend_tag, n_pend_tag;

    logic                        r_out_valid;
    pjt_pkg::t_kind              r_out_kind;
    logic [pjt_pkg::TAG_W-1:0]   r_out_tag;
    logic                        r_out_last;

    logic                        w_slot;
    logic                        w_done;
    logic                        w_fire;
    logic [pjt_pkg::TIME_W-1:0]  w_elapsed;
    logic [CW-1:0]               w_rd_next;
    logic [IW-1:0]               w_rd_addr;
    logic                        w_we;
    logic [IW-1:0]               w_wr_addr;
    pjt_pkg::t_entry             w_wr_data;
    logic                        w_emit;
    pjt_pkg::t_kind              w_emit_kind;
    logic [pjt_pkg::TAG_W-1:0]   w_emit_tag;
    logic                        w_emit_last;

    assign w_slot    = !r_out_valid || i_m_tready;
    assign w_done    = (r_rd == r_count);
    assign w_elapsed = r_now - r_rd_data.last_run;
    assign w_fire    = (w_elapsed > r_rd_data.period);
    assign w_rd_next = r_rd + CW'(1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pjt_pkg::ST_IDLE: begin
                if (i_cmd_valid && i_cmd.op == pjt_pkg::OP_TICK) begin
                    n_state = pjt_pkg::ST_SCAN;
                end
            end
            pjt_pkg::ST_SCAN: begin
                if (w_done && w_slot) begin
                    n_state = pjt_pkg::ST_IDLE;
                end
            end
            default: n_state = pjt_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd_pop   = 1'b0;
        n_count     = r_count;
        n_rd        = r_rd;
        n_wr        = r_wr;
        n_now       = r_now;
        n_pend      = r_pend;
        n_pend_tag  = r_pend_tag;
        w_rd_addr   = r_rd[IW-1:0];
        w_we        = 1'b0;
        w_wr_addr   = r_count[IW-1:0];
        w_wr_data   = r_rd_data;
        w_emit      = 1'b0;
        w_emit_kind = pjt_pkg::KIND_ADD_OK;
        w_emit_tag  = '0;
        w_emit_last = 1'b1;
        unique case (r_state)
            pjt_pkg::ST_IDLE: begin
                w_rd_addr = '0;
                if (i_cmd_valid) begin
                    if (i_cmd.op == pjt_pkg::OP_TICK) begin
                        o_cmd_pop = 1'b1;
                        n_now     = i_cmd.value;
                        n_rd      = '0;
                        n_wr      = '0;
                        n_pend    = 1'b0;
                    end else if (w_slot) begin
                        o_cmd_pop = 1'b1;
                        w_emit    = 1'b1;
                        if (r_count == CW'(MAX_JOBS)) begin
                            w_emit_kind = pjt_pkg::KIND_FULL;
                        end else begin
                            w_emit_kind        = pjt_pkg::KIND_ADD_OK;
                            w_we               = 1'b1;
                            w_wr_addr          = r_count[IW-1:0];
                            w_wr_data.period   = i_cmd.value;
                            w_wr_data.last_run = '0;
                            w_wr_data.tag      = i_cmd.tag;
                            n_count            = r_count + CW'(1);
                        end
                    end
                end
            end
            pjt_pkg::ST_SCAN: begin
                if (w_done) begin
                    if (w_slot) begin
                        w_emit      = 1'b1;
                        w_emit_kind = r_pend ? pjt_pkg::KIND_FIRED : pjt_pkg::KIND_IDLE_TICK;
                        w_emit_tag  = r_pend ? r_pend_tag : '0;
                        w_emit_last = 1'b1;
                        n_count     = r_wr;
                    end
                end else if (!(w_fire && r_pend) || w_slot) begin
                    // advance to the next job; flush the held firing when a new one arrives
                    n_rd      = w_rd_next;
                    w_rd_addr = w_rd_next[IW-1:0];
                    if (w_fire) begin
                        n_pend     = 1'b1;
                        n_pend_tag = r_rd_data.tag;
                        if (r_pend) begin
                            w_emit      = 1'b1;
                            w_emit_kind = pjt_pkg::KIND_FIRED;
                            w_emit_tag  = r_pend_tag;
                            w_emit_last = 1'b0;
                        end
                    end
                    if (r_rd_data.period != '0) begin
                        w_we               = 1'b1;
                        w_wr_addr          = r_wr[IW-1:0];
                        w_wr_data.period   = r_rd_data.period;
                        w_wr_data.last_run = w_fire ? r_now : r_rd_data.last_run;
                        w_wr_data.tag      = r_rd_data.tag;
                        n_wr               = r_wr + CW'(1);
                    end
                end
            end
            default: begin
                w_rd_addr = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_table[w_wr_addr] <= w_wr_data;
        end
        r_rd_data <= r_table[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_rd       <= n_rd;
        r_wr       <= n_wr;
        r_now      <= n_now;
        r_pend_tag <= n_pend_tag;
        if (w_emit) begin
            r_out_kind <= w_emit_kind;
            r_out_tag  <= w_emit_tag;
            r_out_last <= w_emit_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pjt_pkg::ST_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_tag;
    assign o_m_tuser  = r_out_kind;
    assign o_m_tlast  = r_out_last;

endmodule
`default_nettype wire

>>> hdl/periodic_job_timer_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_job_timer_table
// Table of up to MAX_JOBS periodic jobs, fed by add and tick items.
// ----------------------------------------------------------------------------
// An add item (tuser 0) appends a job and returns one result: kind 0, or
// kind 1 when the table is full. A tick item (tuser 1) returns one kind-2
// result per fired job in table order, or a single kind-3 result when nothing
// fires; tlast marks the final result of each item. Input items land in a
// two-entry command queue, so the input accepts up to two items while results
// wait. On a tick the sequencer walks the job table memory, which has one read
// and one write port, one job per cycle unless a result stall holds it, while
// compacting it in place. Results stall a tick when a firing, or its final
// result, must be passed on while the result register is still occupied; an
// add waits for the same register.
module periodic_job_timer_table #(
    parameter int MAX_JOBS = pjt_pkg::MAX_JOBS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // period_ms [63:0], job_tag [79:64], now_ms [143:80]
    input  wire logic [143:0]  s_axis_tdata,
    // op
    input  wire logic [0:0]    s_axis_tuser,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // fired_tag
    output logic [15:0]        m_axis_tdata,
    // kind
    output logic [1:0]         m_axis_tuser,
    output logic               m_axis_tlast
);

    logic          w_cmd_valid;
    pjt_pkg::t_cmd w_cmd;
    logic          w_cmd_pop;

    pjt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_axis_tvalid),
        .o_s_tready  (s_axis_tready),
        .i_s_tuser   (s_axis_tuser),
        .i_s_tdata   (s_axis_tdata),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    pjt_back #(
        .MAX_JOBS (MAX_JOBS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .o_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .o_m_tdata   (m_axis_tdata),
        .o_m_tuser   (m_axis_tuser),
        .o_m_tlast   (m_axis_tlast)
    );

endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the periodic job timer table. Add and tick items
// are streamed in with random gaps while a scoreboard keeps its own copy of
// the job table, predicts every add status and every fired tag, and compares
// each result item in order against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
    import pjt_pkg::*;

    localparam int          JOBS        = MAX_JOBS_DEF;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int          LONG_HOLD   = 300;
    localparam int          MAX_REPORTS = 10;

    typedef struct packed {
        t_kind            kind;
        logic [TAG_W-1:0] tag;
        logic             last;
    } t_outcome;

    class fire_scoreboard;
        logic [TIME_W-1:0] period_tab   [JOBS];
        logic [TIME_W-1:0] last_run_tab [JOBS];
        logic [TAG_W-1:0]  tag_tab      [JOBS];
        int unsigned       job_cnt;
        t_outcome          due_q[$];
        int unsigned       errors;

        function new();
            job_cnt = 0;
            errors  = 0;
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("mismatch: %s", msg);
        endfunction

        function void note_item(t_op op, logic [TIME_W-1:0] period, logic [TAG_W-1:0] tag,
                                logic [TIME_W-1:0] now);
            t_outcome          res;
            t_outcome          prev;
            bit                have_prev;
            logic [TIME_W-1:0] p;
            logic [TIME_W-1:0] lr;
            logic [TIME_W-1:0] diff;
            int unsigned       w;
            res.tag  = '0;
            res.last = 1'b1;
            if (op == OP_ADD) begin
                if (job_cnt >= JOBS) begin
                    res.kind = KIND_FULL;
                end else begin
                    period_tab[job_cnt]   = period;
                    last_run_tab[job_cnt] = '0;
                    tag_tab[job_cnt]      = tag;
                    job_cnt++;
                    res.kind = KIND_ADD_OK;
                end
                due_q.push_back(res);
                return;
            end
            have_prev = 1'b0;
            w = 0;
            for (int unsigned r = 0; r < job_cnt; r++) begin
                p    = period_tab[r];
                lr   = last_run_tab[r];
                diff = now - lr;
                if (diff > p) begin
                    if (have_prev)
                        due_q.push_back(prev);
                    prev.kind = KIND_FIRED;
                    prev.tag  = tag_tab[r];
                    prev.last = 1'b0;
                    have_prev = 1'b1;
                    lr = now;
                end
                if (p != '0) begin
                    period_tab[w]   = p;
                    last_run_tab[w] = lr;
                    tag_tab[w]      = tag_tab[r];
                    w++;
                end
            end
            job_cnt = w;
            if (have_prev) begin
                prev.last = 1'b1;
                due_q.push_back(prev);
            end else begin
                res.kind = KIND_IDLE_TICK;
                due_q.push_back(res);
            end
        endfunction

        function void check_result(t_kind kind, logic [TAG_W-1:0] tag, logic last);
            t_outcome exp;
            if (due_q.size() == 0) begin
                flag($sformatf("unexpected result kind %0d tag %h last %b", kind, tag, last));
                return;
            end
            exp = due_q.pop_front();
            if (exp.kind !== kind || exp.tag !== tag || exp.last !== last)
                flag($sformatf("expected kind %0d tag %h last %b, got kind %0d tag %h last %b",
                               exp.kind, exp.tag, exp.last, kind, tag, last));
        endfunction
    endclass

    logic          i_clk         = 1'b0;
    logic          i_rst_n       = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    // period_ms [63:0], job_tag [79:64], now_ms [143:80]
    logic [143:0]  s_axis_tdata  = '0;
    // op
    logic [0:0]    s_axis_tuser  = '0;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    // fired_tag
    logic [15:0]   m_axis_tdata;
    // kind
    logic [1:0]    m_axis_tuser;
    logic          m_axis_tlast;

    fire_scoreboard    sb;
    int                tx_idle_pct = 0;
    int                rx_idle_pct = 0;
    bit                hold_req    = 1'b0;
    int unsigned       cycles      = 0;
    logic [TIME_W-1:0] clock_ms    = '0;

    periodic_job_timer_table #(.MAX_JOBS(JOBS)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_item(t_op'(s_axis_tuser[0]), s_axis_tdata[63:0], s_axis_tdata[79:64],
                         s_axis_tdata[143:80]);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(t_kind'(m_axis_tuser), m_axis_tdata, m_axis_tlast);
    end

    // hold off for a long stretch on request, else stall at the phase rate
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    function automatic logic [TIME_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic send_item(input t_op op, input logic [TIME_W-1:0] period,
                             input logic [TAG_W-1:0] tag, input logic [TIME_W-1:0] now);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {now, tag, period};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.due_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic add_job(input logic [TIME_W-1:0] period, input logic [TAG_W-1:0] tag);
        send_item(OP_ADD, period, tag, rand64());
    endtask

    task automatic tick(input logic [TIME_W-1:0] now);
        send_item(OP_TICK, rand64(), TAG_W'($urandom), now);
    endtask

    task automatic run_phase(input int n, input int tx_pct, input int rx_pct, input int hold_at);
        t_op               op;
        logic [TIME_W-1:0] per;
        int                sel;
        int                burst_left;
        burst_left  = 0;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int i = 0; i < n; i++) begin
            if (i == hold_at)
                hold_req = 1'b1;
            if (burst_left > 0) begin
                op = OP_ADD;
                burst_left--;
            end else begin
                sel = $urandom_range(99);
                if (sel < 4)
                    burst_left = 12;
                op = (sel >= 4 && sel < 50) ? OP_TICK : OP_ADD;
            end
            if (op == OP_ADD) begin
                sel = $urandom_range(99);
                if (sel < 85)
                    per = '0;
                else if (sel < 95)
                    per = TIME_W'($urandom_range(1, 40));
                else if (sel < 98)
                    per = rand64();
                else
                    per = '1;
                add_job(per, TAG_W'($urandom));
            end else begin
                sel = $urandom_range(99);
                if (sel < 80)
                    clock_ms = clock_ms + TIME_W'($urandom_range(0, 25));
                else if (sel < 90)
                    clock_ms = rand64();
                else
                    clock_ms = clock_ms - TIME_W'($urandom_range(1, 50));
                tick(clock_ms);
            end
        end
        drain();
    endtask

    initial begin
        sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_pct = 17;
        rx_idle_pct = 49;
        tick('0);
        add_job('0, 16'h0000);
        add_job('1, 16'hFFFF);
        add_job(64'd5, 16'h1234);
        add_job('0, 16'h0001);
        add_job(64'd3, 16'h0002);
        tick('0);
        add_job('0, 16'h0007);
        tick(64'd10);
        add_job('0, 16'h00AA);
        add_job('0, 16'h00BB);
        tick('1);
        tick(64'd3);
        for (int i = 0; i < 13; i++)
            add_job('0, 16'h0100 + 16'(i));
        add_job(64'd1, 16'hDEAD);
        tick(64'h8000_0000_0000_0000);
        drain();
        clock_ms = 64'h8000_0000_0000_0000;

        run_phase(50, 17, 49, -1);
        run_phase(50, 49, 17, -1);
        run_phase(42, 0, 0, 5);

        repeat (64) @(posedge i_clk);
        if (sb.errors == 0 && sb.due_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

>>> files.f
hdl/pjt_pkg.sv
hdl/pjt_front.sv
hdl/pjt_back.sv
hdl/periodic_job_timer_table.sv
tb/sv/testbench.sv
